@@ hdl/windowed_rms_current_meter_defines.svh @@
// ----------------------------------------------------------------------------
// Windowed RMS current meter: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RMS_CURRENT_METER_DEFINES_SVH
`define WINDOWED_RMS_CURRENT_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WRMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wrms_pkg.sv @@
// ----------------------------------------------------------------------------
// Windowed RMS current meter package
// Fixed widths, register indexes, reset values and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package wrms_pkg;

    // field and register widths
    localparam int ZERO_W    = 16;
    localparam int WLEN_W    = 9;
    localparam int GAIN_W    = 16;
    localparam int OUT_W     = 20;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    // accumulator and root datapath
    localparam int SUM_W     = 48;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int ALU_W     = ROOT_W + 2;
    localparam int STEP_W    = $clog2(SUM_W);
    localparam int PROD_W    = ROOT_W + GAIN_W;

    // fixed-point scaling
    localparam int Q4_SHIFT   = 4;
    localparam int FRAC_BITS  = 12;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    localparam logic [OUT_W-1:0] OUT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR   = 2'd3;

    // register reset values
    localparam logic [ZERO_W-1:0] RST_ZERO_OFFSET   = 16'd20248;
    localparam logic [WLEN_W-1:0] RST_WINDOW_LENGTH = 9'd80;
    localparam logic [GAIN_W-1:0] RST_GAIN          = 16'd6150;
    localparam logic [OUT_W-1:0]  RST_NOISE_FLOOR   = 20'd260;

    // sequencer to divide/root unit
    typedef struct packed {
        logic start;
    } t_dsu_ctl;

    // divide/root unit to sequencer
    typedef struct packed {
        logic done;
    } t_dsu_sts;

endpackage

`default_nettype wire

@@ hdl/wrms_dsu.sv @@
// ----------------------------------------------------------------------------
// Shared divide / square-root unit
// One subtract-compare datapath, first a restoring divide of the window sum
// by the window length (one quotient bit a cycle), then a digit-by-digit
// integer square root of the quotient (one root bit a cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module wrms_dsu
    import wrms_pkg::*;
#(
    parameter int LEN_W = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dsu_ctl          i_ctl,
    input  wire logic [SUM_W-1:0]  i_dividend,
    input  wire logic [LEN_W-1:0]  i_divisor,
    output t_dsu_sts               o_sts,
    output logic [ROOT_W-1:0]      o_root
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SQRT = 2'd2;

    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

    logic [1:0]        r_state;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SUM_W-1:0]  r_work;
    logic [ALU_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [ALU_W-1:0]  w_alu_a;
    logic [ALU_W-1:0]  w_alu_b;
    logic [ALU_W:0]    w_diff;
    logic              w_ge;

    // operand select for the shared subtractor
    always_comb begin
        if (r_state == S_SQRT) begin
            w_alu_a = {r_rem[ALU_W-3:0], r_work[SUM_W-1 -: 2]};
            w_alu_b = {r_root, 2'b01};
        end else begin
            w_alu_a = {r_rem[ALU_W-2:0], r_work[SUM_W-1]};
            w_alu_b = ALU_W'(i_divisor);
        end
        w_diff = {1'b0, w_alu_a} - {1'b0, w_alu_b};
        w_ge   = ~w_diff[ALU_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (i_ctl.start) begin
                        r_state <= S_DIV;
                        r_step  <= '0;
                    end
                end
                S_DIV: begin
                    if (r_step == DIV_LAST) begin
                        r_state <= S_SQRT;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (r_step == SQRT_LAST) begin
                        r_state <= S_IDLE;
                        r_done  <= 1'b1;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath: work register holds dividend, then quotient, then root input
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    r_work <= i_dividend;
                    r_rem  <= '0;
                    r_root <= '0;
                end
            end
            S_DIV: begin
                r_work <= {r_work[SUM_W-2:0], w_ge};
                if (r_step == DIV_LAST) begin
                    r_rem <= '0;
                end else begin
                    r_rem <= w_ge ? w_diff[ALU_W-1:0] : w_alu_a;
                end
            end
            S_SQRT: begin
                r_work <= {r_work[SUM_W-3:0], 2'b00};
                r_rem  <= w_ge ? w_diff[ALU_W-1:0] : w_alu_a;
                r_root <= {r_root[ROOT_W-2:0], w_ge};
            end
            default: begin
                r_work <= r_work;
            end
        endcase
    end

    assign o_sts.done = r_done;
    assign o_root     = r_root;

endmodule

`default_nettype wire

@@ hdl/windowed_rms_current_meter.sv @@
// ----------------------------------------------------------------------------
// Windowed RMS current meter
// Accumulates squared offset-corrected ADC samples and reports the RMS
// current in milliamps once per window.
// ----------------------------------------------------------------------------
// Each accepted sample (one transaction on the input channel) is turned into
// |zero_offset - sample*16|, squared and added to a saturating 48-bit sum.
// A sample that does not close the window passes through difference, square
// and add; the block drops o_in_ready for that time. The sample that closes
// the window also starts the shared divide/root unit: a restoring divide by
// the effective window length, a square root, then handoff, gain multiply and
// output formatting, plus any wait for the output register to be taken. The
// result sits in an output register, so the next sample may be accepted while
// it waits. Window length 0 acts as 1 and lengths above MAX_WINDOW act as
// MAX_WINDOW. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_rms_current_meter
    import wrms_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int MAX_WINDOW  = 256
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,
    // sample channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    // result channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [OUT_W-1:0]            o_rms_ma
);

    localparam int MAG_W = (SAMPLE_BITS + Q4_SHIFT > ZERO_W) ?
                           (SAMPLE_BITS + Q4_SHIFT) : ZERO_W;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int MA_W  = PROD_W + 1 - FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQR  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    // configuration registers
    logic [ZERO_W-1:0] r_zero_offset;
    logic [WLEN_W-1:0] r_window_length;
    logic [GAIN_W-1:0] r_gain;
    logic [OUT_W-1:0]  r_noise_floor;

    // sequencer and window state
    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [LEN_W-1:0]  r_count;
    logic [LEN_W-1:0]  n_count;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_rms_ma;

    // datapath registers
    logic [MAG_W-1:0]  r_mag;
    logic [SQ_W-1:0]   r_sq;
    logic [PROD_W-1:0] r_prod;

    logic [LEN_W-1:0]  w_len;
    logic [MAG_W-1:0]  w_zero_ext;
    logic [MAG_W-1:0]  w_scaled;
    logic [SUM_W:0]    w_sum_add;
    logic              w_close;
    logic [PROD_W:0]   w_round;
    logic [MA_W-1:0]   w_ma_full;
    logic [OUT_W-1:0]  w_ma_sat;
    logic [OUT_W-1:0]  w_ma;
    logic              w_in_acc;
    logic              w_out_load;

    t_dsu_ctl          w_dsu_ctl;
    t_dsu_sts          w_dsu_sts;
    logic [ROOT_W-1:0] w_root;

    // Effective window length: zero acts as one, clamp at MAX_WINDOW.
    always_comb begin
        if (r_window_length == '0) begin
            w_len = LEN_W'(1);
        end else if (32'(r_window_length) > MAX_WINDOW) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = LEN_W'(r_window_length);
        end
    end

    // Configuration writes; the two-bit index selects one of the four registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset   <= RST_ZERO_OFFSET;
            r_window_length <= RST_WINDOW_LENGTH;
            r_gain          <= RST_GAIN;
            r_noise_floor   <= RST_NOISE_FLOOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ZERO_OFFSET:   r_zero_offset   <= i_cfg_wdata[ZERO_W-1:0];
                REG_WINDOW_LENGTH: r_window_length <= i_cfg_wdata[WLEN_W-1:0];
                REG_GAIN:          r_gain          <= i_cfg_wdata[GAIN_W-1:0];
                REG_NOISE_FLOOR:   r_noise_floor   <= i_cfg_wdata[OUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid & o_in_ready;

    // Absolute difference between the zero level and the Q4 sample.
    assign w_zero_ext = MAG_W'(r_zero_offset);
    assign w_scaled   = MAG_W'({i_sample, {Q4_SHIFT{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mag <= (w_zero_ext >= w_scaled) ? (w_zero_ext - w_scaled)
                                              : (w_scaled - w_zero_ext);
        end
        if (r_state == S_SQR) begin
            r_sq <= r_mag * r_mag;
        end
        if (r_state == S_MUL) begin
            r_prod <= w_root * r_gain;
        end
    end

    // Saturating accumulate and window close decision.
    always_comb begin
        w_sum_add = {1'b0, r_sum} + (SUM_W + 1)'(r_sq);
        n_sum     = w_sum_add[SUM_W] ? SUM_MAX : w_sum_add[SUM_W-1:0];
        n_count   = r_count + 1'b1;
        w_close   = (n_count >= w_len);
    end

    // Hand the closed window sum straight to the divide/root unit.
    assign w_dsu_ctl.start = (r_state == S_ACC) && w_close;

    wrms_dsu #(
        .LEN_W (LEN_W)
    ) u_dsu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_dsu_ctl),
        .i_dividend (n_sum),
        .i_divisor  (w_len),
        .o_sts      (w_dsu_sts),
        .o_root     (w_root)
    );

    // Round to whole milliamps, saturate, then apply the noise floor.
    always_comb begin
        w_round   = {1'b0, r_prod} + (PROD_W + 1)'(ROUND_HALF);
        w_ma_full = w_round[PROD_W:FRAC_BITS];
        w_ma_sat  = (w_ma_full > MA_W'(OUT_MAX)) ? OUT_MAX : w_ma_full[OUT_W-1:0];
        w_ma      = (w_ma_sat < r_noise_floor) ? '0 : w_ma_sat;
    end

    // Output register may load only when empty or being drained.
    assign w_out_load = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_SQR;
            S_SQR:  n_state = S_ACC;
            S_ACC:  n_state = w_close ? S_ROOT : S_IDLE;
            S_ROOT: if (w_dsu_sts.done) n_state = S_MUL;
            S_MUL:  n_state = S_FIN;
            S_FIN:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_ACC) begin
                // clear the window when it closes, otherwise advance it
                r_count <= w_close ? '0 : n_count;
                r_sum   <= w_close ? '0 : n_sum;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_rms_ma <= w_ma;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rms_ma    = r_rms_ma;

endmodule

`default_nettype wire

@@ hdl/wrms_checker.sv @@
// ----------------------------------------------------------------------------
// Windowed RMS current meter checker
// Port-level assertions on handshake timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "windowed_rms_current_meter_defines.svh"

module wrms_checker
    import wrms_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [OUT_W-1:0] o_rms_ma
);

    // a stalled result holds its value
    `WRMS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_rms_ma), "stalled result changed or dropped")

    // every accepted sample keeps the block busy for square and add
    `WRMS_ASSERT_NXT(a_busy_after_acc, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready ##1 !o_in_ready, "sample accepted while still accumulating")

    // a new result only appears after a busy cycle of the sequencer
    `WRMS_ASSERT_IMP(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(!o_in_ready), "result appeared without a closing window")

endmodule

bind windowed_rms_current_meter wrms_checker u_wrms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_rms_ma    (o_rms_ma)
);

`default_nettype wire

@@ tb/tb_windowed_rms_current_meter.sv @@
// ----------------------------------------------------------------------------
// Windowed RMS current meter testbench
// Feeds ADC samples through the valid/ready input channel and checks every
// RMS result against a hand-typed value or an in-bench model of the accumulate,
// mean, root, gain, saturation and noise-floor steps. A directed table comes
// first, then random configuration phases with random idling on both channels
// and one long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_windowed_rms_current_meter;
    timeunit 1ns;
    timeprecision 1ps;

    import wrms_pkg::*;

    localparam int SAMPLE_BITS    = 12;
    localparam int WIN_MAX        = 256;
    // a window-closing sample keeps the block busy through divide and root; leave margin
    localparam int SETTLE_CYCLES  = 100;
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_AT        = 25;
    localparam int HOLD_CYCLES    = 400;
    localparam int CALM_LO        = 900;
    localparam int CALM_HI        = 1200;
    localparam int RANDOM_SAMPLES = 1800;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } t_row_kind;

    // one row of the directed table: a register write or a sample, with an
    // optional hand-typed RMS value
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
        logic [SAMPLE_BITS-1:0] smp;
        logic                   typed;
        logic [OUT_W-1:0]       want;
    } t_stim_row;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    logic [SAMPLE_BITS-1:0] i_sample    = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [OUT_W-1:0]       o_rms_ma;

    // model copy of the configuration registers
    logic [ZERO_W-1:0] cfg_zero  = RST_ZERO_OFFSET;
    logic [WLEN_W-1:0] cfg_wlen  = RST_WINDOW_LENGTH;
    logic [GAIN_W-1:0] cfg_gain  = RST_GAIN;
    logic [OUT_W-1:0]  cfg_floor = RST_NOISE_FLOOR;

    // model copy of the window state
    logic [SUM_W-1:0] acc_sum = '0;
    int               acc_cnt = 0;

    logic [OUT_W-1:0] rms_due_q[$];
    t_stim_row        dir_rows[$];

    int n_samples = 0;
    int n_rms     = 0;
    int n_errors  = 0;
    int n_stall   = 0;
    bit cfg_open  = 1'b0;

    windowed_rms_current_meter #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (WIN_MAX)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rms_ma    (o_rms_ma)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Build the root one bit at a time from the top, keeping a bit whenever
    // the square of the candidate still fits under the operand.
    function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [SUM_W-1:0] v);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] cand;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            cand = r | (ROOT_W'(1) << b);
            if ({{ROOT_W{1'b0}}, cand} * {{ROOT_W{1'b0}}, cand} <= v) begin
                r = cand;
            end
        end
        return r;
    endfunction

    // Advance the window by one sample; return 1 with the RMS value in ma
    // when the sample closes the window.
    function automatic bit rms_window_step(input logic [SAMPLE_BITS-1:0] smp,
                                           output logic [OUT_W-1:0] ma);
        logic [ZERO_W-1:0]   scaled;
        logic [ZERO_W-1:0]   mag;
        logic [2*ZERO_W-1:0] sq;
        logic [SUM_W-1:0]    mean;
        logic [ROOT_W-1:0]   root;
        logic [63:0]         prod;
        int                  len;
        scaled = ZERO_W'(smp) << Q4_SHIFT;
        mag    = (cfg_zero >= scaled) ? cfg_zero - scaled : scaled - cfg_zero;
        sq     = mag * mag;
        // saturate rather than wrap the accumulator
        if (SUM_W'(sq) > SUM_MAX - acc_sum) begin
            acc_sum = SUM_MAX;
        end else begin
            acc_sum = acc_sum + SUM_W'(sq);
        end
        acc_cnt++;
        ma = '0;
        // zero length acts as one, anything past the maximum acts as the maximum
        if (cfg_wlen == 0) begin
            len = 1;
        end else if (cfg_wlen > WIN_MAX) begin
            len = WIN_MAX;
        end else begin
            len = int'(cfg_wlen);
        end
        // a shortened window closes on the first sample that reaches it
        if (acc_cnt < len) begin
            return 1'b0;
        end
        mean = acc_sum / SUM_W'(len);
        root = floor_sqrt(mean);
        prod = (64'(root) * 64'(cfg_gain) + 64'(ROUND_HALF)) >> FRAC_BITS;
        if (prod > 64'(OUT_MAX)) begin
            prod = 64'(OUT_MAX);
        end
        ma = (prod < 64'(cfg_floor)) ? '0 : prod[OUT_W-1:0];
        acc_sum = '0;
        acc_cnt = 0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle with a chance of 21 in a hundred, except in the calm stretch.
    function automatic bit take_break();
        if (n_samples >= CALM_LO && n_samples < CALM_HI) begin
            return 1'b0;
        end
        return $urandom_range(99) < 21;
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        dir_rows.push_back('{ROW_WRITE, idx, data, '0, 1'b0, '0});
    endfunction

    function automatic void add_sample(input logic [SAMPLE_BITS-1:0] smp);
        dir_rows.push_back('{ROW_SAMPLE, '0, '0, smp, 1'b0, '0});
    endfunction

    function automatic void add_known(input logic [SAMPLE_BITS-1:0] smp,
                                      input logic [OUT_W-1:0] want);
        dir_rows.push_back('{ROW_SAMPLE, '0, '0, smp, 1'b1, want});
    endfunction

    // Mostly samples near the zero level (realistic currents), some uniform,
    // some at the rails.
    function automatic logic [SAMPLE_BITS-1:0] draw_sample(input logic [ZERO_W-1:0] zero);
        int roll;
        int c;
        roll = $urandom_range(99);
        if (roll < 60) begin
            c = int'(zero >> Q4_SHIFT) + int'($urandom_range(400)) - 200;
            if (c < 0) c = 0;
            if (c > 4095) c = 4095;
        end else if (roll < 85) begin
            c = $urandom_range(4095);
        end else begin
            c = $urandom_range(1) ? 4095 : 0;
        end
        return SAMPLE_BITS'(c);
    endfunction

    // Drop valid, drain every pending result, then let the last sample
    // finish its pass through the datapath.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (rms_due_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Hold the write enable high across back-to-back writes; the first write
    // of a group waits for the block to go idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        if (!cfg_open) settle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        cfg_open = 1'b1;
        case (idx)
            REG_ZERO_OFFSET:   cfg_zero  = data[ZERO_W-1:0];
            REG_WINDOW_LENGTH: cfg_wlen  = data[WLEN_W-1:0];
            REG_GAIN:          cfg_gain  = data[GAIN_W-1:0];
            REG_NOISE_FLOOR:   cfg_floor = data[OUT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic close_cfg();
        if (cfg_open) begin
            i_cfg_we <= 1'b0;
            cfg_open = 1'b0;
        end
    endtask

    // Offer one sample, hold it until the transaction completes, and queue
    // the expected RMS value if it closes a window. Returns at the next
    // falling edge with valid still high, so the caller decides what follows.
    task automatic push_sample(input logic [SAMPLE_BITS-1:0] smp, input logic typed,
                               input logic [OUT_W-1:0] want);
        logic [OUT_W-1:0] ma;
        close_cfg();
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= smp;
        do @(posedge i_clk); while (!o_in_ready);
        n_samples++;
        if (rms_window_step(smp, ma)) begin
            rms_due_q.push_back(typed ? want : ma);
        end
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: random ready, plus one long hold-off early in the run
    // while the sender keeps offering samples.
    // ------------------------------------------------------------------------
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_samples >= HOLD_AT) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_ready <= !take_break();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [OUT_W-1:0] exp_ma;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_rms++;
            if (rms_due_q.size() == 0) begin
                $error("rms_ma: unexpected transaction, actual %0d", o_rms_ma);
                n_errors++;
            end else begin
                exp_ma = rms_due_q.pop_front();
                if (o_rms_ma !== exp_ma) begin
                    $error("rms_ma: expected %0d, actual %0d", exp_ma, o_rms_ma);
                    n_errors++;
                end
            end
        end
        // count cycles with no transaction and no register write
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            n_stall <= 0;
        end else begin
            n_stall <= n_stall + 1;
        end
        if (n_stall >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_stim_row        row;
        int               n_dir;
        int               phase;
        int               roll;
        int               eff;
        int               n;
        logic [CFG_W-1:0] zero_v;
        logic [CFG_W-1:0] wlen_v;
        logic [CFG_W-1:0] gain_v;
        logic [CFG_W-1:0] floor_v;

        // Directed table. Typed values are the ones obvious by inspection:
        // zero difference, zero gain, floor above any reachable current.
        add_write(REG_WINDOW_LENGTH, 1);
        add_sample(0);
        add_sample(4095);
        add_write(REG_ZERO_OFFSET, 20240);
        add_known(1265, 0);
        add_sample(1266);                       // 24 mA, below the reset floor
        add_write(REG_NOISE_FLOOR, 24);
        add_sample(1266);                       // exactly at the floor
        add_write(REG_NOISE_FLOOR, 25);
        add_sample(1266);                       // one below the floor
        add_write(REG_ZERO_OFFSET, 0);
        add_write(REG_NOISE_FLOOR, 0);
        add_sample(4095);
        add_write(REG_GAIN, 65535);
        add_sample(4095);                       // largest difference above zero level
        add_write(REG_ZERO_OFFSET, 65535);
        add_sample(0);                          // largest difference overall
        add_write(REG_NOISE_FLOOR, OUT_MAX);
        add_known(0, 0);
        add_write(REG_NOISE_FLOOR, 0);
        add_write(REG_GAIN, 0);
        add_known(2730, 0);
        add_write(REG_GAIN, RST_GAIN);
        add_write(REG_ZERO_OFFSET, RST_ZERO_OFFSET);
        add_write(REG_WINDOW_LENGTH, 0);        // acts as length one
        add_sample(1365);
        add_sample(3000);
        add_write(REG_WINDOW_LENGTH, 3);
        add_sample(2730);
        add_sample(100);
        add_sample(4000);
        add_sample(7);                          // leave two samples in the window
        add_sample(2048);
        add_write(REG_WINDOW_LENGTH, 1);        // shorten the window mid-way
        add_sample(3000);

        // hold reset low from time zero, release on a falling edge
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.idx, row.data);
            end else begin
                push_sample(row.smp, row.typed, row.want);
            end
        end
        n_dir = n_samples;

        // Random phases: new settings each phase, whole windows of samples,
        // sometimes a partial window left for the next setting to close.
        phase = 0;
        while (n_samples < n_dir + RANDOM_SAMPLES) begin
            if (phase == 0) begin
                // one result per sample so the receiver hold-off backs up the block
                zero_v  = RST_ZERO_OFFSET;
                wlen_v  = 1;
                gain_v  = RST_GAIN;
                floor_v = 0;
                n       = 60;
            end else begin
                roll = $urandom_range(19);
                if (roll == 0) zero_v = 0;
                else if (roll == 1) zero_v = 65535;
                else if (roll < 5) zero_v = $urandom_range(65535);
                else zero_v = 32768 + $urandom_range(16000) - 8000;

                roll = $urandom_range(19);
                if (roll == 0) wlen_v = 0;
                else if (roll == 1) wlen_v = WIN_MAX;
                else if (roll == 2) wlen_v = $urandom_range(511, WIN_MAX + 1);
                else if (roll < 6) wlen_v = $urandom_range(80, 17);
                else wlen_v = $urandom_range(16, 1);

                roll = $urandom_range(19);
                if (roll == 0) gain_v = 0;
                else if (roll == 1) gain_v = 65535;
                else if (roll < 5) gain_v = $urandom_range(65535);
                else gain_v = $urandom_range(12000, 2000);

                roll = $urandom_range(19);
                if (roll < 4) floor_v = 0;
                else if (roll == 4) floor_v = OUT_MAX;
                else if (roll < 12) floor_v = $urandom_range(500);
                else floor_v = $urandom_range(6000);

                eff = (wlen_v == 0) ? 1 : (wlen_v > WIN_MAX) ? WIN_MAX : int'(wlen_v);
                n = eff * ((eff > 64) ? 1 : $urandom_range(4, 1));
                if ($urandom_range(3) == 0) n += $urandom_range(eff - 1);
            end
            write_reg(REG_ZERO_OFFSET, zero_v);
            write_reg(REG_WINDOW_LENGTH, wlen_v);
            write_reg(REG_GAIN, gain_v);
            write_reg(REG_NOISE_FLOOR, floor_v);
            for (int s = 0; s < n; s++) begin
                push_sample(draw_sample(cfg_zero), 1'b0, '0);
            end
            phase++;
        end

        // drain everything, then wait out one more datapath pass
        close_cfg();
        settle();

        $display("Run covered %0d samples (%0d directed) over %0d random settings, %0d RMS results",
                 n_samples, n_dir, phase, n_rms);
        $display("Windows of length 0 to 511, rail samples and gains, one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ windowed_rms_current_meter.f @@
+incdir+hdl
hdl/wrms_pkg.sv
hdl/wrms_dsu.sv
hdl/windowed_rms_current_meter.sv
hdl/wrms_checker.sv
tb/tb_windowed_rms_current_meter.sv
